// ===== sv/go_back_n_send_window_unit_macros.svh =====
// Assertion macros shared by the go-back-N send window unit.
`ifndef GO_BACK_N_SEND_WINDOW_UNIT_MACROS_SVH
`define GO_BACK_N_SEND_WINDOW_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define GBN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define GBN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/gbn_pkg.sv =====
// Shared types, codes and constants of the go-back-N send window unit.
package gbn_pkg;

	localparam int SEQ_W = 20;
	localparam int WIN_W = 7;
	localparam int TMO_W = 16;
	localparam int DUP_W = 4;
	localparam int CMD_W = 2;
	localparam int IDX_W = 2;

	localparam logic [SEQ_W-1:0] SEQ_MAX = 20'd999999;
	localparam logic [SEQ_W-1:0] SEQ_SAT = 20'hFFFFF;
	localparam logic [WIN_W-1:0] MAX_SPAN = 7'd65;
	localparam logic [DUP_W-1:0] DUP_SAT = 4'd15;

	// Register reset values
	localparam logic [SEQ_W-1:0] PACKET_COUNT_RST = 20'd1;
	localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = 7'd55;
	localparam logic [TMO_W-1:0] TIMEOUT_TICKS_RST = 16'd25;
	localparam logic [DUP_W-1:0] DUP_LIMIT_RST = 4'd3;

	// Item commands
	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_PACKET_COUNT = 2'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW_SIZE = 2'd1;
	localparam logic [IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;
	localparam logic [IDX_W-1:0] REG_DUP_LIMIT = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic take;
		logic open_win;
		logic load_cur;
		logic emit_burst;
		logic emit_done;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic item_live;
		logic done_hit;
		logic trigger;
		logic win_empty;
		logic burst_last;
		logic slot_free;
	} dp_stat_t;

endpackage

// ===== sv/gbn_dp.sv =====
// Datapath of the go-back-N send window: registers, window state and output register.
module gbn_dp #(
	parameter logic [gbn_pkg::SEQ_W-1:0] SEQ_MAX = gbn_pkg::SEQ_MAX
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gbn_pkg::IDX_W-1:0]     cfg_index,
	input  logic [gbn_pkg::SEQ_W-1:0]     cfg_data,
	input  logic [gbn_pkg::CMD_W-1:0]     command,
	input  logic [gbn_pkg::SEQ_W-1:0]     ack_number,
	input  logic                          out_ready,
	input  gbn_pkg::ctrl_cmd_t            cmd,
	output gbn_pkg::dp_stat_t             stat,
	output logic                          out_valid,
	output logic [gbn_pkg::SEQ_W-1:0]     send_seq,
	output logic                          last_of_burst,
	output logic                          all_done
);

	localparam int SW = gbn_pkg::SEQ_W;

	logic [SW-1:0]                 packet_count_q;
	logic [gbn_pkg::WIN_W-1:0]     window_size_q;
	logic [gbn_pkg::TMO_W-1:0]     timeout_ticks_q;
	logic [gbn_pkg::DUP_W-1:0]     dup_limit_q;

	logic [SW-1:0]                 highest_ack_q;
	logic [SW-1:0]                 window_end_q;
	logic [gbn_pkg::DUP_W-1:0]     dup_count_q;
	logic [gbn_pkg::TMO_W-1:0]     idle_ticks_q;
	logic                          active_q;
	logic [SW-1:0]                 cur_q;
	logic [SW-1:0]                 stop_q;

	logic                          out_valid_q;
	logic [SW-1:0]                 send_seq_q;
	logic                          last_q;
	logic                          done_q;

	logic [SW-1:0]                 limit;
	logic [SW-1:0]                 ack_c;
	logic [gbn_pkg::WIN_W-1:0]     span;
	logic [SW:0]                   end_sum;
	logic [SW-1:0]                 end_sat;
	logic [SW:0]                   ha_inc;
	logic [SW-1:0]                 we_dec;
	logic                          slot_free;

	// Clamp the packet count and the incoming ack to the sequence ceiling
	assign limit = (packet_count_q > SEQ_MAX) ? SEQ_MAX : packet_count_q;
	assign ack_c = (ack_number > SEQ_MAX) ? SEQ_MAX : ack_number;

	// Window end for a new burst, saturated
	assign span    = (window_size_q > gbn_pkg::MAX_SPAN) ? gbn_pkg::MAX_SPAN : window_size_q;
	assign end_sum = {1'b0, highest_ack_q} + {{(SW + 1 - gbn_pkg::WIN_W){1'b0}}, span};
	assign end_sat = end_sum[SW] ? gbn_pkg::SEQ_SAT : end_sum[SW-1:0];

	assign ha_inc = {1'b0, highest_ack_q} + {{SW{1'b0}}, 1'b1};
	assign we_dec = window_end_q - {{(SW - 1){1'b0}}, 1'b1};

	assign slot_free = !out_valid_q || out_ready;

	// Report status to the controller
	always_comb begin
		stat.item_live  = (command == gbn_pkg::CMD_START) ||
			(active_q && ((command == gbn_pkg::CMD_ACK) || (command == gbn_pkg::CMD_TICK)));
		stat.done_hit   = highest_ack_q >= limit;
		stat.trigger    = (ha_inc >= {1'b0, window_end_q}) || (dup_count_q >= dup_limit_q) ||
			(idle_ticks_q >= timeout_ticks_q);
		stat.win_empty  = ha_inc >= {1'b0, window_end_q};
		stat.burst_last = cur_q == stop_q;
		stat.slot_free  = slot_free;
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_count_q  <= gbn_pkg::PACKET_COUNT_RST;
			window_size_q   <= gbn_pkg::WINDOW_SIZE_RST;
			timeout_ticks_q <= gbn_pkg::TIMEOUT_TICKS_RST;
			dup_limit_q     <= gbn_pkg::DUP_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gbn_pkg::REG_PACKET_COUNT:  packet_count_q  <= cfg_data;
				gbn_pkg::REG_WINDOW_SIZE:   window_size_q   <= cfg_data[gbn_pkg::WIN_W-1:0];
				gbn_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[gbn_pkg::TMO_W-1:0];
				gbn_pkg::REG_DUP_LIMIT:     dup_limit_q     <= cfg_data[gbn_pkg::DUP_W-1:0];
				default: ;
			endcase
		end
	end

	// Update the transfer state on items, bursts and completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_ack_q <= '0;
			window_end_q  <= {{(SW - 1){1'b0}}, 1'b1};
			dup_count_q   <= '0;
			idle_ticks_q  <= '0;
			active_q      <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (command == gbn_pkg::CMD_START) begin
					highest_ack_q <= '0;
					window_end_q  <= {{(SW - 1){1'b0}}, 1'b1};
					dup_count_q   <= '0;
					idle_ticks_q  <= '0;
					active_q      <= 1'b1;
				end else if (active_q && command == gbn_pkg::CMD_ACK) begin
					if (ack_c > highest_ack_q) begin
						highest_ack_q <= ack_c;
						dup_count_q   <= '0;
					end else if (ack_c == highest_ack_q) begin
						if (dup_count_q < gbn_pkg::DUP_SAT)
							dup_count_q <= dup_count_q + 1'b1;
					end else begin
						dup_count_q <= '0;
					end
				end else if (active_q && command == gbn_pkg::CMD_TICK) begin
					if (idle_ticks_q < timeout_ticks_q)
						idle_ticks_q <= idle_ticks_q + 1'b1;
				end
			end
			if (cmd.open_win) begin
				window_end_q <= end_sat;
				dup_count_q  <= '0;
				idle_ticks_q <= '0;
			end
			if (cmd.emit_done)
				active_q <= 1'b0;
		end
	end

	// Hold the burst cursor and its final packet number
	always_ff @(posedge clk) begin
		if (cmd.load_cur) begin
			cur_q  <= ha_inc[SW-1:0];
			stop_q <= (we_dec < limit) ? we_dec : limit;
		end else if (cmd.emit_burst) begin
			cur_q <= cur_q + 1'b1;
		end
	end

	// Output register: drop the beat when taken, load a new one when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_burst || cmd.emit_done)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_burst) begin
			send_seq_q <= cur_q;
			last_q     <= cur_q == stop_q;
			done_q     <= 1'b0;
		end else if (cmd.emit_done) begin
			send_seq_q <= '0;
			last_q     <= 1'b1;
			done_q     <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign send_seq      = send_seq_q;
	assign last_of_burst = last_q;
	assign all_done      = done_q;

endmodule

// ===== sv/gbn_ctrl.sv =====
// Controller state machine of the go-back-N send window.
module gbn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gbn_pkg::dp_stat_t  stat,
	output gbn_pkg::ctrl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EVAL  = 2'd1;
	localparam logic [1:0] ST_SETUP = 2'd2;
	localparam logic [1:0] ST_BURST = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = state_q == ST_IDLE;

	// Decode commands and the next state
	always_comb begin
		state_d        = state_q;
		cmd.take       = 1'b0;
		cmd.open_win   = 1'b0;
		cmd.load_cur   = 1'b0;
		cmd.emit_burst = 1'b0;
		cmd.emit_done  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (stat.item_live)
						state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.done_hit) begin
					if (stat.slot_free) begin
						cmd.emit_done = 1'b1;
						state_d       = ST_IDLE;
					end
				end else if (stat.trigger) begin
					cmd.open_win = 1'b1;
					state_d      = ST_SETUP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SETUP: begin
				cmd.load_cur = 1'b1;
				state_d      = stat.win_empty ? ST_IDLE : ST_BURST;
			end
			ST_BURST: begin
				if (stat.slot_free) begin
					cmd.emit_burst = 1'b1;
					if (stat.burst_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== sv/go_back_n_send_window_unit.sv =====
// Go-back-N sender window: takes start, ack and tick items and emits the packet numbers to send,
// one beat per cycle while the output slot is free, ending with a single completion beat. The
// unit handles one item at a time: an ack or tick that comes while no transfer runs is taken and
// ignored; any other item is accepted and then checked for completion or a trigger, and a triggered
// window is set up before its packet numbers go out, an empty burst ending after the setup. The
// steps are set by the controller state machine and its single output register; a waiting beat
// that is not yet taken holds back the next beat or the completion beat. The input is taken again
// while the last beat still waits.
module go_back_n_send_window_unit #(
	parameter logic [gbn_pkg::SEQ_W-1:0] SEQ_MAX = gbn_pkg::SEQ_MAX
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gbn_pkg::IDX_W-1:0]     cfg_index,
	input  logic [gbn_pkg::SEQ_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gbn_pkg::CMD_W-1:0]     command,
	input  logic [gbn_pkg::SEQ_W-1:0]     ack_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gbn_pkg::SEQ_W-1:0]     send_seq,
	output logic                          last_of_burst,
	output logic                          all_done
);

	`include "go_back_n_send_window_unit_macros.svh"

	gbn_pkg::ctrl_cmd_t cmd;
	gbn_pkg::dp_stat_t  stat;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gbn_dp #(
		.SEQ_MAX (SEQ_MAX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.ack_number    (ack_number),
		.out_ready     (out_ready),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.send_seq      (send_seq),
		.last_of_burst (last_of_burst),
		.all_done      (all_done)
	);

	// A completion beat carries packet number zero and closes its item
	`GBN_ASSERT_SAME(a_done_beat, clk, arst_n, out_valid && all_done, last_of_burst && (send_seq == '0), "completion beat malformed")
	// No new item is taken while a burst is going out
	`GBN_ASSERT_SAME(a_no_take_in_burst, clk, arst_n, cmd.emit_burst || cmd.emit_done, !in_ready, "item accepted during burst")
	// Every emitted result shows up on the output
	`GBN_ASSERT_NEXT(a_emit_visible, clk, arst_n, cmd.emit_burst || cmd.emit_done, out_valid, "emitted beat lost")

endmodule
